### rtl/core/lfu_pkg.sv
`timescale 1ns / 1ps

package lfu_pkg;

  // Default sizes of the frame table
  localparam int LOG_FRAMES_DEF = 4;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int COUNT_BITS_DEF = 16;

  // Process identifier width is fixed
  localparam int PID_BITS = 8;

  // Operation codes
  localparam logic OP_FAULT  = 1'b0;
  localparam logic OP_ACCESS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } lfu_state_e;

endpackage

### rtl/core/lfu_ram.sv
`timescale 1ns / 1ps

module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             re_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/lfu_page_frame_replacement.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  op, page, process_id, frame_index, is_write
// out      output     out_valid_o/out_stall_i frame, replaced, write_back, victim_process,
//                                             victim_page, clear_tlb
//
// An access reads its frame's use count and writes it back raised; one to a frame not yet
// filled is dropped. A fault with a free frame goes straight to the emit step; one on a full
// table first scans the frames, one use-count compare per cycle against the count memory's single read port.
// Reset empties the table at once: frames fill in order, so a fill count marks validity.
// The input is stalled while an item is in work; a waiting result in the output register
// stalls only the final step of the next fault.

module lfu_page_frame_replacement #(
  parameter int LOG_FRAMES = lfu_pkg::LOG_FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [PAGE_BITS-1:0]         page_i,
  input  logic [lfu_pkg::PID_BITS-1:0] process_id_i,
  input  logic [LOG_FRAMES-1:0]        frame_index_i,
  input  logic                         is_write_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [LOG_FRAMES-1:0]        frame_o,
  output logic                         replaced_o,
  output logic                         write_back_o,
  output logic [lfu_pkg::PID_BITS-1:0] victim_process_o,
  output logic [PAGE_BITS-1:0]         victim_page_o,
  output logic                         clear_tlb_o
);

  import lfu_pkg::*;

  localparam int NFRAMES = 1 << LOG_FRAMES;
  localparam int META_W  = COUNT_BITS + 1;
  localparam int TAG_W   = PID_BITS + PAGE_BITS;

  lfu_state_e state_q, state_d;

  logic [LOG_FRAMES:0]   fill_q, fill_d;
  logic [LOG_FRAMES-1:0] cnt_q, cnt_d;
  logic [LOG_FRAMES-1:0] best_q, best_d;
  logic [COUNT_BITS-1:0] best_cnt_q, best_cnt_d;
  logic                  best_dirty_q, best_dirty_d;
  logic                  free_q, free_d;
  logic [PAGE_BITS-1:0]  page_q, page_d;
  logic [PID_BITS-1:0]   pid_q, pid_d;
  logic                  wr_q, wr_d;

  logic                  out_valid_q, out_valid_d;
  logic [LOG_FRAMES-1:0] frame_q, frame_d;
  logic                  replaced_q, replaced_d;
  logic                  write_back_q, write_back_d;
  logic [PID_BITS-1:0]   vproc_q, vproc_d;
  logic [PAGE_BITS-1:0]  vpage_q, vpage_d;
  logic                  clear_tlb_q, clear_tlb_d;

  logic                  in_acc;
  logic                  full;
  logic                  out_free;
  logic                  last;

  logic                  meta_we, meta_re;
  logic [LOG_FRAMES-1:0] meta_wr_addr, meta_rd_addr;
  logic [META_W-1:0]     meta_wr_data, meta_rd_data;
  logic                  tag_we, tag_re;
  logic [LOG_FRAMES-1:0] tag_rd_addr;
  logic [TAG_W-1:0]      tag_rd_data;

  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_dirty;
  logic [PID_BITS-1:0]   tag_owner;
  logic [PAGE_BITS-1:0]  tag_page;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign full      = fill_q[LOG_FRAMES];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign last      = (cnt_q == {LOG_FRAMES{1'b1}});

  assign rd_cnt    = meta_rd_data[COUNT_BITS-1:0];
  assign rd_dirty  = meta_rd_data[COUNT_BITS];
  assign tag_owner = tag_rd_data[TAG_W-1:PAGE_BITS];
  assign tag_page  = tag_rd_data[PAGE_BITS-1:0];

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    best_d       = best_q;
    best_cnt_d   = best_cnt_q;
    best_dirty_d = best_dirty_q;
    free_d       = free_q;
    page_d       = page_q;
    pid_d        = pid_q;
    wr_d         = wr_q;

    out_valid_d  = out_valid_q && out_stall_i;
    frame_d      = frame_q;
    replaced_d   = replaced_q;
    write_back_d = write_back_q;
    vproc_d      = vproc_q;
    vpage_d      = vpage_q;
    clear_tlb_d  = clear_tlb_q;

    meta_we      = 1'b0;
    meta_re      = 1'b0;
    meta_wr_addr = best_q;
    meta_wr_data = '0;
    meta_rd_addr = '0;
    tag_we       = 1'b0;
    tag_re       = 1'b0;
    tag_rd_addr  = best_d;

    unique case (state_q)
      S_IDLE: begin
        page_d = page_i;
        pid_d  = process_id_i;
        wr_d   = is_write_i;
        best_d = frame_index_i;
        if (in_acc) begin
          if (op_i == OP_ACCESS) begin
            // Drop accesses to frames not yet filled
            if ({1'b0, frame_index_i} < fill_q) begin
              meta_re      = 1'b1;
              meta_rd_addr = frame_index_i;
              state_d      = S_ACC;
            end
          end else if (!full) begin
            free_d  = 1'b1;
            best_d  = fill_q[LOG_FRAMES-1:0];
            fill_d  = fill_q + 1'b1;
            state_d = S_EMIT;
          end else begin
            free_d       = 1'b0;
            meta_re      = 1'b1;
            meta_rd_addr = '0;
            cnt_d        = '0;
            state_d      = S_SCAN;
          end
        end
      end

      S_ACC: begin
        meta_we      = 1'b1;
        meta_wr_addr = best_q;
        meta_wr_data = {rd_dirty | wr_q,
                        (rd_cnt == {COUNT_BITS{1'b1}}) ? rd_cnt : rd_cnt + 1'b1};
        state_d      = S_IDLE;
      end

      S_SCAN: begin
        // One compare per frame; strict less keeps the lowest index on ties
        if (cnt_q == '0 || rd_cnt < best_cnt_q) begin
          best_d       = cnt_q;
          best_cnt_d   = rd_cnt;
          best_dirty_d = rd_dirty;
        end
        if (last) begin
          tag_re  = 1'b1;
          state_d = S_EMIT;
        end else begin
          meta_re      = 1'b1;
          meta_rd_addr = cnt_q + 1'b1;
          cnt_d        = cnt_q + 1'b1;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          frame_d      = best_q;
          replaced_d   = !free_q;
          write_back_d = !free_q && best_dirty_q;
          vproc_d      = free_q ? '0 : tag_owner;
          vpage_d      = free_q ? '0 : tag_page;
          clear_tlb_d  = !free_q && (tag_owner == pid_q);
          // Install the new page, clean with zero count
          meta_we      = 1'b1;
          meta_wr_addr = best_q;
          meta_wr_data = '0;
          tag_we       = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    best_q       <= best_d;
    best_cnt_q   <= best_cnt_d;
    best_dirty_q <= best_dirty_d;
    free_q       <= free_d;
    page_q       <= page_d;
    pid_q        <= pid_d;
    wr_q         <= wr_d;
    frame_q      <= frame_d;
    replaced_q   <= replaced_d;
    write_back_q <= write_back_d;
    vproc_q      <= vproc_d;
    vpage_q      <= vpage_d;
    clear_tlb_q  <= clear_tlb_d;
  end

  // Use count with dirty bit on top
  lfu_ram #(
    .WIDTH (META_W),
    .DEPTH (NFRAMES)
  ) u_meta_ram (
    .clk_i     (clk_i),
    .we_i      (meta_we),
    .wr_addr_i (meta_wr_addr),
    .wr_data_i (meta_wr_data),
    .re_i      (meta_re),
    .rd_addr_i (meta_rd_addr),
    .rd_data_o (meta_rd_data)
  );

  // Owner process and virtual page
  lfu_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NFRAMES)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .we_i      (tag_we),
    .wr_addr_i (best_q),
    .wr_data_i ({pid_q, page_q}),
    .re_i      (tag_re),
    .rd_addr_i (tag_rd_addr),
    .rd_data_o (tag_rd_data)
  );

  assign out_valid_o      = out_valid_q;
  assign frame_o          = frame_q;
  assign replaced_o       = replaced_q;
  assign write_back_o     = write_back_q;
  assign victim_process_o = vproc_q;
  assign victim_page_o    = vpage_q;
  assign clear_tlb_o      = clear_tlb_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lfu_pkg::*;

  localparam int NFRAMES   = 1 << LOG_FRAMES_DEF;
  localparam int PAGE_W    = PAGE_BITS_DEF;
  localparam int COUNT_W   = COUNT_BITS_DEF;
  localparam int FRAME_W   = LOG_FRAMES_DEF;
  localparam int IDLE_PCT  = 8;
  localparam int DRAIN_CYC = 40;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic                replaced;
    logic                write_back;
    logic [PID_BITS-1:0] victim_process;
    logic [PAGE_W-1:0]   victim_page;
    logic                clear_tlb;
  } fault_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                op = OP_ACCESS;
  logic [PAGE_W-1:0]   page = '0;
  logic [PID_BITS-1:0] process_id = '0;
  logic [FRAME_W-1:0]  frame_index = '0;
  logic                is_write = 1'b0;
  logic                out_stall = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic [FRAME_W-1:0]  frame_o;
  logic                replaced_o;
  logic                write_back_o;
  logic [PID_BITS-1:0] victim_process_o;
  logic [PAGE_W-1:0]   victim_page_o;
  logic                clear_tlb_o;

  // Shadow frame table
  logic                frm_valid [NFRAMES];
  logic [PID_BITS-1:0] frm_owner [NFRAMES];
  logic [PAGE_W-1:0]   frm_page  [NFRAMES];
  logic [COUNT_W-1:0]  frm_count [NFRAMES];
  logic                frm_dirty [NFRAMES];

  fault_result_t pending_faults_q[$];
  int error_count = 0;
  bit idle_on = 1'b1;
  int hold_left = 0;

  lfu_page_frame_replacement u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .op_i             (op),
    .page_i           (page),
    .process_id_i     (process_id),
    .frame_index_i    (frame_index),
    .is_write_i       (is_write),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .frame_o          (frame_o),
    .replaced_o       (replaced_o),
    .write_back_o     (write_back_o),
    .victim_process_o (victim_process_o),
    .victim_page_o    (victim_page_o),
    .clear_tlb_o      (clear_tlb_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic void clear_frame_table();
    for (int i = 0; i < NFRAMES; i++) begin
      frm_valid[i] = 1'b0;
      frm_owner[i] = '0;
      frm_page[i]  = '0;
      frm_count[i] = '0;
      frm_dirty[i] = 1'b0;
    end
  endfunction

  // Apply one accepted transaction to the shadow table; queue the fault outcome.
  function automatic void apply_to_frame_table(input logic t_op, input logic [PAGE_W-1:0] t_page,
                                               input logic [PID_BITS-1:0] t_pid,
                                               input logic [FRAME_W-1:0] t_idx,
                                               input logic t_wr);
    fault_result_t res;
    int victim;
    bit found_free;
    res = '0;
    victim = 0;
    found_free = 1'b0;
    if (t_op == OP_ACCESS) begin
      if (frm_valid[t_idx]) begin
        if (frm_count[t_idx] != {COUNT_W{1'b1}}) frm_count[t_idx]++;
        if (t_wr) frm_dirty[t_idx] = 1'b1;
      end
      return;
    end
    for (int i = 0; i < NFRAMES; i++) begin
      if (!found_free && !frm_valid[i]) begin
        found_free = 1'b1;
        victim = i;
      end
    end
    if (!found_free) begin
      for (int i = 1; i < NFRAMES; i++)
        if (frm_count[i] < frm_count[victim]) victim = i;
      res.replaced       = 1'b1;
      res.write_back     = frm_dirty[victim];
      res.victim_process = frm_owner[victim];
      res.victim_page    = frm_page[victim];
      res.clear_tlb      = (frm_owner[victim] == t_pid);
    end
    res.frame = FRAME_W'(victim);
    pending_faults_q.push_back(res);
    frm_valid[victim] = 1'b1;
    frm_owner[victim] = t_pid;
    frm_page[victim]  = t_page;
    frm_count[victim] = '0;
    frm_dirty[victim] = 1'b0;
  endfunction

  // Offer one transaction and hold it until accepted.
  task automatic send_item(input logic t_op, input logic [PAGE_W-1:0] t_page,
                           input logic [PID_BITS-1:0] t_pid, input logic [FRAME_W-1:0] t_idx,
                           input logic t_wr);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    op          <= t_op;
    page        <= t_page;
    process_id  <= t_pid;
    frame_index <= t_idx;
    is_write    <= t_wr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_to_frame_table(t_op, t_page, t_pid, t_idx, t_wr);
  endtask

  // Receiver stall: long hold when requested, random otherwise.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    fault_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_faults_q.size() == 0) begin
        report_mismatch("unexpected result frame", 32'(frame_o), '0);
      end else begin
        want = pending_faults_q.pop_front();
        check_field("frame", 32'(frame_o), 32'(want.frame));
        check_field("replaced", 32'(replaced_o), 32'(want.replaced));
        check_field("write_back", 32'(write_back_o), 32'(want.write_back));
        check_field("victim_process", 32'(victim_process_o), 32'(want.victim_process));
        check_field("victim_page", 32'(victim_page_o), 32'(want.victim_page));
        check_field("clear_tlb", 32'(clear_tlb_o), 32'(want.clear_tlb));
      end
    end
  end

  task automatic test_table_fill();
    logic [PAGE_W-1:0] pg;
    // Access to an empty frame must be dropped
    send_item(OP_ACCESS, '0, 8'd0, 4'd3, 1'b1);
    for (int i = 0; i < NFRAMES; i++) begin
      pg = PAGE_W'($urandom());
      if (i == 0) send_item(OP_FAULT, '0, 8'd0, 4'd0, 1'b0);
      else if (i == 1) send_item(OP_FAULT, {PAGE_W{1'b1}}, 8'hFF, 4'hF, 1'b1);
      else send_item(OP_FAULT, pg, PID_BITS'(i), FRAME_W'(i), 1'b0);
    end
    send_item(OP_ACCESS, '0, 8'd0, 4'd0, 1'b1);
    send_item(OP_ACCESS, '0, 8'd0, 4'd1, 1'b0);
    // Same owner as the victim, then a different one
    send_item(OP_FAULT, 20'h12345, 8'd2, 4'd0, 1'b0);
    send_item(OP_FAULT, 20'hABCDE, 8'd200, 4'd0, 1'b0);
    send_item(OP_ACCESS, '0, 8'd0, 4'hF, 1'b1);
  endtask

  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    // Raise every frame but one, so the faults pick the one left behind
    for (int i = 0; i < NFRAMES; i++)
      if (i != 5) send_item(OP_ACCESS, '0, 8'd0, FRAME_W'(i), 1'b1);
    send_item(OP_FAULT, 20'h0F0F0, 8'd77, 4'd0, 1'b0);
    send_item(OP_FAULT, 20'hF0F0F, 8'd78, 4'd0, 1'b0);
    for (int n = 0; n < 200; n++)
      send_item(($urandom_range(0, 99) < 35) ? OP_FAULT : OP_ACCESS, PAGE_W'($urandom()),
                PID_BITS'($urandom_range(1, 4)), FRAME_W'($urandom()), 1'($urandom()));
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    hold_left = 300;
    for (int n = 0; n < 30; n++)
      send_item($urandom_range(0, 1) ? OP_FAULT : OP_ACCESS, PAGE_W'($urandom()),
                PID_BITS'($urandom_range(1, 4)), FRAME_W'($urandom()), 1'($urandom()));
  endtask

  task automatic test_random_traffic();
    logic                t_op;
    logic [PID_BITS-1:0] t_pid;
    logic [FRAME_W-1:0]  t_idx;
    for (int n = 0; n < 1250; n++) begin
      t_op  = ($urandom_range(0, 99) < 35) ? OP_FAULT : OP_ACCESS;
      t_pid = $urandom_range(0, 1) ? PID_BITS'($urandom_range(1, 4)) : PID_BITS'($urandom());
      // Favor a few hot frames so counts spread out
      t_idx = $urandom_range(0, 1) ? FRAME_W'($urandom_range(0, 3)) : FRAME_W'($urandom());
      send_item(t_op, PAGE_W'($urandom()), t_pid, t_idx, 1'($urandom()));
    end
  endtask

  initial begin
    clear_frame_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_fill();
    test_no_idle_stretch();
    test_output_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_faults_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
